// File: rtl/world_to_screen_projection_macros.svh
// ----------------------------------------------------------------------------
// World-to-screen projection: assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_MACROS_SVH

// Same-cycle implication
`define WSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define WSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wsp_pkg.sv
// ----------------------------------------------------------------------------
// World-to-screen projection package
// Shared widths, register reset values and types of the projection pipeline.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int COORD_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int SCREEN_BITS_DEF = 12;

    localparam int NUM_PAIRS  = 8;
    localparam int PAIR_W     = 64;
    localparam int COEF_W     = 32;
    localparam int NUM_COEF   = 16;
    localparam int CLIP_W     = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int TRANS_BASE = 12;

    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_Z = 2;
    localparam int ROW_W = 3;

    localparam logic [CLIP_W-1:0] CLIP_LIM = 64'h0FFF_FFFF_FFFF_FFFF;

    typedef logic [NUM_COEF-1:0][COEF_W-1:0]  t_matrix;
    typedef logic [NUM_PAIRS-1:0][PAIR_W-1:0] t_pairs;
    typedef logic [3:0][CLIP_W-1:0]           t_clip;

    typedef struct packed {
        logic valid;
        logic w_zero;
    } t_div_ctl;

    // Identity matrix
    localparam t_pairs PAIR_RESET = {
        64'h0001_0000_0000_0000, 64'd0, 64'd65536, 64'd0,
        64'd0, 64'h0001_0000_0000_0000, 64'd0, 64'd65536
    };

endpackage

// File: rtl/wsp_cfg.sv
// ----------------------------------------------------------------------------
// Matrix coefficient registers
// Holds the eight coefficient pairs and splits them into sixteen entries.
// ----------------------------------------------------------------------------
module wsp_cfg import wsp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAIR_W-1:0]    i_cfg_data,
    output t_matrix              o_mat
);

    localparam int IDX_BITS = $clog2(NUM_PAIRS);

    t_pairs r_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair <= PAIR_RESET;
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_PAIRS))) begin
            r_pair[i_cfg_index[IDX_BITS-1:0]] <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        for (int k = 0; k < NUM_PAIRS; k++) begin
            o_mat[2*k]   = r_pair[k][COEF_W-1:0];
            o_mat[2*k+1] = r_pair[k][PAIR_W-1:COEF_W];
        end
    end

endmodule

// File: rtl/wsp_clip.sv
// ----------------------------------------------------------------------------
// Clip-space transform
// Three stages: split partial products, floor shift and clamp, row sums.
// ----------------------------------------------------------------------------
module wsp_clip import wsp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int SIDE_W     = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic [SIDE_W-1:0]            i_side,
    input  t_matrix                      i_mat,
    output logic                         o_valid,
    output t_clip                        o_clip,
    output logic [SIDE_W-1:0]            o_side
);

    localparam int LO_W = COORD_BITS / 2;
    localparam int HI_W = COORD_BITS - LO_W;
    localparam int PH_W = HI_W + COEF_W;
    localparam int PL_W = LO_W + 1 + COEF_W;
    localparam int P_W  = COORD_BITS + COEF_W + 1;
    localparam int PE_W = (P_W > CLIP_W) ? P_W : CLIP_W;
    localparam logic signed [PE_W-1:0] LIM_P = PE_W'(CLIP_LIM);
    localparam logic signed [PE_W-1:0] LIM_N = -LIM_P;

    logic signed [COORD_BITS-1:0] w_pos [3];

    logic                     r_v1, r_v2, r_v3;
    logic [SIDE_W-1:0]        r_side1, r_side2, r_side3;
    logic signed [PH_W-1:0]   r_ph   [4][3];
    logic signed [PL_W-1:0]   r_pl   [4][3];
    logic signed [PE_W-1:0]   n_term [4][3];
    logic signed [CLIP_W-1:0] r_term [4][3];
    t_clip                    n_clip;
    t_clip                    r_clip;

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        logic signed [PE_W-1:0] v_prod;
        logic signed [PE_W-1:0] v_sh;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                v_prod = (PE_W'(r_ph[r][c]) <<< LO_W) + PE_W'(r_pl[r][c]);
                v_sh   = v_prod >>> FRAC_BITS;
                if (v_sh > LIM_P) begin
                    n_term[r][c] = LIM_P;
                end else if (v_sh < LIM_N) begin
                    n_term[r][c] = LIM_N;
                end else begin
                    n_term[r][c] = v_sh;
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_clip[r] = r_term[r][0] + r_term[r][1] + r_term[r][2]
                      + CLIP_W'($signed(i_mat[TRANS_BASE+r]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_ph[r][c] <= $signed(w_pos[c][COORD_BITS-1:LO_W])
                                * $signed(i_mat[4*c+r]);
                    r_pl[r][c] <= $signed({1'b0, w_pos[c][LO_W-1:0]})
                                * $signed(i_mat[4*c+r]);
                    r_term[r][c] <= CLIP_W'(n_term[r][c]);
                end
            end
            r_clip  <= n_clip;
            r_side1 <= i_side;
            r_side2 <= r_side1;
            r_side3 <= r_side2;
        end
    end

    assign o_valid = r_v3;
    assign o_clip  = r_clip;
    assign o_side  = r_side3;

endmodule

// File: rtl/wsp_div.sv
// ----------------------------------------------------------------------------
// Perspective divide
// Restoring divider, one quotient bit per stage, three lanes sharing clip w.
// ----------------------------------------------------------------------------
module wsp_div import wsp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int SIDE_W     = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  t_clip                      i_clip,
    input  logic [SIDE_W-1:0]          i_side,
    output t_div_ctl                   o_ctl,
    output logic [2:0][COORD_BITS-1:0] o_quot,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int QB   = COORD_BITS - 1;
    localparam int SH_W = (FRAC_BITS > QB) ? FRAC_BITS : QB;
    localparam int DV_W = CLIP_W + SH_W;
    localparam int NST  = QB;
    localparam logic [COORD_BITS-1:0] QMAX = {1'b0, {QB{1'b1}}};
    localparam logic [COORD_BITS-1:0] QMIN = {1'b1, {QB{1'b0}}};

    logic [CLIP_W-1:0] n_den;
    logic [CLIP_W-1:0] n_ud;
    logic [CLIP_W-1:0] n_un  [3];
    logic [2:0]        n_neg;
    logic [2:0]        n_ovf;
    logic              n_wz;

    logic              r_v    [NST+1];
    logic [DV_W-1:0]   r_rem  [NST+1][3];
    logic [QB-1:0]     r_q    [NST+1][3];
    logic [CLIP_W-1:0] r_ud   [NST+1];
    logic [2:0]        r_neg  [NST+1];
    logic [2:0]        r_ovf  [NST+1];
    logic              r_wz   [NST+1];
    logic [SIDE_W-1:0] r_side [NST+1];

    logic [2:0][COORD_BITS-1:0] n_quot;
    logic [2:0][COORD_BITS-1:0] r_quot;
    t_div_ctl                   r_ctl;
    logic [SIDE_W-1:0]          r_side_o;

    always_comb begin
        n_den = i_clip[ROW_W];
        n_ud  = n_den[CLIP_W-1] ? ('0 - n_den) : n_den;
        n_wz  = (n_den == '0);
        for (int l = 0; l < 3; l++) begin
            n_un[l]  = i_clip[l][CLIP_W-1] ? ('0 - i_clip[l]) : i_clip[l];
            n_neg[l] = i_clip[l][CLIP_W-1] ^ n_den[CLIP_W-1];
            n_ovf[l] = (DV_W'(n_un[l]) << FRAC_BITS) >= (DV_W'(n_ud) << QB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NST; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ctl <= '0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < NST; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_ctl.valid  <= r_v[NST];
            r_ctl.w_zero <= r_wz[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= DV_W'(n_un[l]) << FRAC_BITS;
                r_q[0][l]   <= '0;
            end
            r_ud[0]   <= n_ud;
            r_neg[0]  <= n_neg;
            r_ovf[0]  <= n_ovf;
            r_wz[0]   <= n_wz;
            r_side[0] <= i_side;
            for (int k = 0; k < NST; k++) begin
                for (int l = 0; l < 3; l++) begin
                    if (r_rem[k][l] >= (DV_W'(r_ud[k]) << (QB-1-k))) begin
                        r_rem[k+1][l] <= r_rem[k][l] - (DV_W'(r_ud[k]) << (QB-1-k));
                        r_q[k+1][l]   <= r_q[k][l] | (QB'(1) << (QB-1-k));
                    end else begin
                        r_rem[k+1][l] <= r_rem[k][l];
                        r_q[k+1][l]   <= r_q[k][l];
                    end
                end
                r_ud[k+1]   <= r_ud[k];
                r_neg[k+1]  <= r_neg[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_wz[k+1]   <= r_wz[k];
                r_side[k+1] <= r_side[k];
            end
            r_quot   <= n_quot;
            r_side_o <= r_side[NST];
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r_wz[NST]) begin
                n_quot[l] = '0;
            end else if (r_ovf[NST][l]) begin
                n_quot[l] = r_neg[NST][l] ? QMIN : QMAX;
            end else if (r_neg[NST][l]) begin
                n_quot[l] = '0 - {1'b0, r_q[NST][l]};
            end else begin
                n_quot[l] = {1'b0, r_q[NST][l]};
            end
        end
    end

    assign o_ctl  = r_ctl;
    assign o_quot = r_quot;
    assign o_side = r_side_o;

endmodule

// File: rtl/wsp_vp.sv
// ----------------------------------------------------------------------------
// Viewport mapping
// Scales NDC x and y by the half sizes, adds the centre, flips y, saturates.
// ----------------------------------------------------------------------------
module wsp_vp import wsp_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  t_div_ctl                   i_ctl,
    input  logic [2:0][COORD_BITS-1:0] i_quot,
    input  logic [SCREEN_BITS-2:0]     i_half_w,
    input  logic [SCREEN_BITS-2:0]     i_half_h,
    output logic                       o_valid,
    output logic [COORD_BITS-1:0]      o_screen_x,
    output logic [COORD_BITS-1:0]      o_screen_y,
    output logic [COORD_BITS-1:0]      o_ndc_depth,
    output logic                       o_w_zero
);

    localparam int PX_W = COORD_BITS + SCREEN_BITS;
    localparam int HF_W = SCREEN_BITS + FRAC_BITS;
    localparam int VW   = ((PX_W > HF_W) ? PX_W : HF_W) + 1;
    localparam logic signed [VW-1:0] CMAX = VW'({1'b0, {(COORD_BITS-1){1'b1}}});
    localparam logic signed [VW-1:0] CMIN = -CMAX - 1;

    logic                         r_v1, r_v2;
    logic signed [PX_W-1:0]       r_px, r_py;
    logic [SCREEN_BITS-2:0]       r_hw, r_hh;
    logic [COORD_BITS-1:0]        r_nz;
    logic                         r_wz;
    logic signed [VW-1:0]         n_sx, n_sy;
    logic [COORD_BITS-1:0]        n_cx, n_cy;
    logic [COORD_BITS-1:0]        r_sx, r_sy, r_dz;
    logic                         r_wz2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
        end
    end

    always_comb begin
        logic signed [VW-1:0] v_hwf;
        logic signed [VW-1:0] v_hhf;
        v_hwf = VW'($signed({1'b0, r_hw})) <<< FRAC_BITS;
        v_hhf = VW'($signed({1'b0, r_hh})) <<< FRAC_BITS;
        n_sx  = VW'(r_px) + v_hwf;
        n_sy  = v_hhf - VW'(r_py);
        if (n_sx > CMAX) begin
            n_cx = CMAX[COORD_BITS-1:0];
        end else if (n_sx < CMIN) begin
            n_cx = CMIN[COORD_BITS-1:0];
        end else begin
            n_cx = n_sx[COORD_BITS-1:0];
        end
        if (n_sy > CMAX) begin
            n_cy = CMAX[COORD_BITS-1:0];
        end else if (n_sy < CMIN) begin
            n_cy = CMIN[COORD_BITS-1:0];
        end else begin
            n_cy = n_sy[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= $signed({1'b0, i_half_w}) * $signed(i_quot[ROW_X]);
            r_py  <= $signed({1'b0, i_half_h}) * $signed(i_quot[ROW_Y]);
            r_hw  <= i_half_w;
            r_hh  <= i_half_h;
            r_nz  <= i_quot[ROW_Z];
            r_wz  <= i_ctl.w_zero;
            r_sx  <= r_wz ? '0 : n_cx;
            r_sy  <= r_wz ? '0 : n_cy;
            r_dz  <= r_nz;
            r_wz2 <= r_wz;
        end
    end

    assign o_valid     = r_v2;
    assign o_screen_x  = r_sx;
    assign o_screen_y  = r_sy;
    assign o_ndc_depth = r_dz;
    assign o_w_zero    = r_wz2;

endmodule

// File: rtl/world_to_screen_projection.sv
// ----------------------------------------------------------------------------
// World-to-screen projection
// Point times view-projection matrix, perspective divide, viewport mapping.
//
//   port group   direction  carries
//   i_s_*        in         point and screen size, one item per handshake
//   o_m_*        out        screen x, screen y, NDC depth; w-zero flag in tuser
//   *_cfg_*      in         coefficient pair writes, index 0..7
//
// One item per cycle sustained while the output is not stalled; the divider
// resolves one quotient bit per stage.
// All stages move together on one enable; the final stage is the output
// register, so the pipe advances whenever that register is empty or taken.
// Reset is synchronous and loads the identity matrix and clears all valids.
// ----------------------------------------------------------------------------
`include "world_to_screen_projection_macros.svh"

module world_to_screen_projection import wsp_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // pos_x, pos_y, pos_z, screen_width, screen_height
    input  logic [((3*COORD_BITS+2*SCREEN_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // screen_x, screen_y, ndc_depth
    output logic [((3*COORD_BITS+7)/8)*8-1:0] o_m_tdata,
    // w_zero
    output logic [0:0]           o_m_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAIR_W-1:0]    i_cfg_data
);

    localparam int IN_W   = 3*COORD_BITS + 2*SCREEN_BITS;
    localparam int OUT_W  = 3*COORD_BITS;
    localparam int OUT_DW = ((3*COORD_BITS+7)/8)*8;
    localparam int HALF_W = SCREEN_BITS - 1;
    localparam int SIDE_W = 2*HALF_W;

    logic                         w_en;
    t_matrix                      w_mat;
    logic [COORD_BITS-1:0]        w_pos_x, w_pos_y, w_pos_z;
    logic [SCREEN_BITS-1:0]       w_sw, w_sh;
    logic [SIDE_W-1:0]            w_side_in;
    logic                         w_clip_v;
    t_clip                        w_clip;
    logic [SIDE_W-1:0]            w_clip_side;
    t_div_ctl                     w_div_ctl;
    logic [2:0][COORD_BITS-1:0]   w_quot;
    logic [SIDE_W-1:0]            w_div_side;
    logic                         w_out_v;
    logic [COORD_BITS-1:0]        w_sx, w_sy, w_dz;
    logic                         w_wz;

    assign w_pos_x   = i_s_tdata[COORD_BITS-1:0];
    assign w_pos_y   = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_pos_z   = i_s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign w_sw      = i_s_tdata[3*COORD_BITS+SCREEN_BITS-1:3*COORD_BITS];
    assign w_sh      = i_s_tdata[IN_W-1:3*COORD_BITS+SCREEN_BITS];
    assign w_side_in = {w_sh[SCREEN_BITS-1:1], w_sw[SCREEN_BITS-1:1]};

    assign w_en       = !w_out_v || i_m_tready;
    assign o_s_tready = w_en;

    wsp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mat       (w_mat)
    );

    wsp_clip #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .SIDE_W     (SIDE_W)
    ) u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_pos_x (w_pos_x),
        .i_pos_y (w_pos_y),
        .i_pos_z (w_pos_z),
        .i_side  (w_side_in),
        .i_mat   (w_mat),
        .o_valid (w_clip_v),
        .o_clip  (w_clip),
        .o_side  (w_clip_side)
    );

    wsp_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .SIDE_W     (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_clip_v),
        .i_clip  (w_clip),
        .i_side  (w_clip_side),
        .o_ctl   (w_div_ctl),
        .o_quot  (w_quot),
        .o_side  (w_div_side)
    );

    wsp_vp #(
        .COORD_BITS  (COORD_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .SCREEN_BITS (SCREEN_BITS)
    ) u_vp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_ctl       (w_div_ctl),
        .i_quot      (w_quot),
        .i_half_w    (w_div_side[HALF_W-1:0]),
        .i_half_h    (w_div_side[SIDE_W-1:HALF_W]),
        .o_valid     (w_out_v),
        .o_screen_x  (w_sx),
        .o_screen_y  (w_sy),
        .o_ndc_depth (w_dz),
        .o_w_zero    (w_wz)
    );

    assign o_m_tvalid   = w_out_v;
    assign o_m_tdata    = OUT_DW'({w_dz, w_sy, w_sx});
    assign o_m_tuser[0] = w_wz;

    `WSP_ASSERT_NOW(a_wz_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata[OUT_W-1:0] == '0, "w-zero item carries nonzero fields")
    `WSP_ASSERT_NOW(a_empty_ready, i_clk, i_rst_n, !o_m_tvalid, o_s_tready, "empty output stage but input not ready")
    `WSP_ASSERT_NOW(a_take_ready, i_clk, i_rst_n, o_m_tvalid && i_m_tready, o_s_tready, "output taken but pipe not advancing")
    `WSP_ASSERT_NEXT(a_stall_keep, i_clk, i_rst_n, !o_s_tready, o_m_tvalid, "stalled output item lost")

endmodule

// File: bench/world_to_screen_projection_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// World-to-screen projection testbench
// Streams points through the block under a series of matrix settings, with
// random stalls on both sides, and checks every result item against an
// in-bench fixed-point projection of the same point.
// ----------------------------------------------------------------------------
module world_to_screen_projection_tb;
    import wsp_pkg::*;

    localparam int  IN_W      = 120;
    localparam int  OUT_W     = 96;
    localparam int  DRAIN_CYC = 50;
    localparam int  STALL_LIM = 20000;
    localparam longint C_MAX  = 64'sd2147483647;
    localparam longint C_MIN  = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] depth;
        logic        wz;
    } proj_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_tdata;
    logic [0:0]        o_m_tuser;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [PAIR_W-1:0] i_cfg_data = '0;

    logic [IN_W-1:0]   pending_pts[$];
    proj_t             expected_proj[$];
    t_pairs            mdl_pairs = PAIR_RESET;
    bit                calm = 1'b0;
    bit                failed = 1'b0;
    int                result_cnt = 0;
    int                hold_cnt = 0;
    int                quiet_cnt = 0;

    world_to_screen_projection u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint coef(int i);
        logic [31:0] v;
        v = mdl_pairs[i >> 1][(i & 1) * 32 +: 32];
        return longint'(signed'(v));
    endfunction

    function automatic longint sat_coord(longint v);
        if (v > C_MAX) return C_MAX;
        if (v < C_MIN) return C_MIN;
        return v;
    endfunction

    function automatic longint fix_div(longint n, longint d);
        logic [127:0] un, ud, q;
        bit neg;
        neg = (n < 0) != (d < 0);
        un  = 128'(n < 0 ? -n : n);
        ud  = 128'(d < 0 ? -d : d);
        if (un / ud > 128'd32767) q = 128'h8000_0000;
        else q = (un << 16) / ud;
        return sat_coord(neg ? -longint'(q) : longint'(q));
    endfunction

    function automatic proj_t project(logic [IN_W-1:0] d);
        longint pt[3];
        longint clip[4];
        longint hw, hh, nx, ny, nz;
        proj_t  res;
        pt[0] = longint'(signed'(d[31:0]));
        pt[1] = longint'(signed'(d[63:32]));
        pt[2] = longint'(signed'(d[95:64]));
        hw = longint'(d[107:97]);
        hh = longint'(d[119:109]);
        for (int r = 0; r < 4; r++) begin
            clip[r] = coef(TRANS_BASE + r);
            for (int c = 0; c < 3; c++)
                clip[r] += (pt[c] * coef(4 * c + r)) >>> 16;
        end
        res = '0;
        if (clip[ROW_W] == 0) begin
            res.wz = 1'b1;
            return res;
        end
        nx = fix_div(clip[ROW_X], clip[ROW_W]);
        ny = fix_div(clip[ROW_Y], clip[ROW_W]);
        nz = fix_div(clip[ROW_Z], clip[ROW_W]);
        res.sx    = 32'(sat_coord(hw * nx + hw * 65536));
        res.sy    = 32'(sat_coord(hh * 65536 - hh * ny));
        res.depth = 32'(nz);
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pack_pt(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z, logic [11:0] w,
                                                logic [11:0] h);
        return {h, w, z, y, x};
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
            2: return 32'($signed($urandom_range(0, 2 ** 26)) - 2 ** 25);
            default: return 32'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17);
        endcase
    endfunction

    function automatic logic [31:0] rand_coef(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17);
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    // source side: hold the item until taken, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                expected_proj.push_back(project(i_s_tdata));
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_pts.size() > 0 && (calm || $urandom_range(0, 99) >= 37)) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pending_pts.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side: compare each item, stall at random, one long hold-off
    always @(posedge i_clk) begin
        proj_t exp_r;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                result_cnt++;
                if (result_cnt == 130) hold_cnt = 400;
                if (expected_proj.size() == 0) begin
                    $error("unexpected result item");
                    failed = 1'b1;
                end else begin
                    exp_r = expected_proj.pop_front();
                    if (o_m_tdata[31:0] !== exp_r.sx) begin
                        $error("screen_x exp %h got %h", exp_r.sx, o_m_tdata[31:0]);
                        failed = 1'b1;
                    end
                    if (o_m_tdata[63:32] !== exp_r.sy) begin
                        $error("screen_y exp %h got %h", exp_r.sy, o_m_tdata[63:32]);
                        failed = 1'b1;
                    end
                    if (o_m_tdata[95:64] !== exp_r.depth) begin
                        $error("ndc_depth exp %h got %h", exp_r.depth, o_m_tdata[95:64]);
                        failed = 1'b1;
                    end
                    if (o_m_tuser[0] !== exp_r.wz) begin
                        $error("w_zero exp %b got %b", exp_r.wz, o_m_tuser[0]);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= calm || $urandom_range(0, 99) >= 37;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= STALL_LIM) begin
            $display("[world_to_screen_projection] ERROR");
            $finish;
        end
    end

    task automatic write_pair(logic [CFG_IDX_W-1:0] idx, logic [PAIR_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx < NUM_PAIRS) mdl_pairs[idx] = val;
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending_pts.size() > 0 || i_s_tvalid || expected_proj.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic load_matrix(int mode, bit w_off);
        logic [31:0] m[NUM_COEF];
        for (int i = 0; i < NUM_COEF; i++) begin
            m[i] = rand_coef(mode);
            if (w_off && (i % 4) == ROW_W) m[i] = '0;
        end
        for (int k = 0; k < NUM_PAIRS; k++)
            write_pair(CFG_IDX_W'(k), {m[2 * k + 1], m[2 * k]});
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            pending_pts.push_back(pack_pt(rand_coord(), rand_coord(), rand_coord(),
                                          12'($urandom), 12'($urandom)));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity: overflow of the divide, screen size extremes
        pending_pts.push_back(pack_pt(0, 0, 0, 0, 0));
        pending_pts.push_back(pack_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      12'hFFF, 12'hFFF));
        pending_pts.push_back(pack_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      12'hFFF, 12'hFFF));
        pending_pts.push_back(pack_pt(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000,
                                      12'd1, 12'd1));
        pending_pts.push_back(pack_pt(32'h0000_4000, 32'hFFFF_C000, 32'hFFFF_0000,
                                      12'd1920, 12'd1081));
        pending_pts.push_back(pack_pt(32'h0000_7FFF, 32'hFFFF_8001, 32'h0000_0001,
                                      12'hAAA, 12'h555));
        pending_pts.push_back(pack_pt(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                                      12'h555, 12'hAAA));
        drain();

        // clip w always zero
        load_matrix(0, 1'b1);
        pending_pts.push_back(pack_pt(32'h7FFF_FFFF, 32'h8000_0000, 0, 12'hFFF, 0));
        queue_random(5);
        drain();

        // extreme coefficients
        load_matrix(2, 1'b0);
        pending_pts.push_back(pack_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      12'hFFF, 12'hFFF));
        pending_pts.push_back(pack_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      12'hFFF, 12'hFFF));
        queue_random(8);
        drain();

        write_pair(CFG_IDX_W'(NUM_PAIRS + 1), {$urandom, $urandom});
        write_pair(CFG_IDX_W'(8'hFF), {$urandom, $urandom});

        for (int ph = 0; ph < 11; ph++) begin
            load_matrix(ph % 3 == 0 ? 0 : 1, ph == 7);
            calm = (ph == 4);
            queue_random(100);
            drain();
        end
        calm = 1'b0;

        // back to identity
        for (int k = 0; k < NUM_PAIRS; k++)
            write_pair(CFG_IDX_W'(k), PAIR_RESET[k]);
        queue_random(40);
        drain();

        if (!failed && expected_proj.size() == 0) begin
            $display("[world_to_screen_projection] OK");
        end else begin
            $display("[world_to_screen_projection] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/wsp_pkg.sv
rtl/wsp_cfg.sv
rtl/wsp_clip.sv
rtl/wsp_div.sv
rtl/wsp_vp.sv
rtl/world_to_screen_projection.sv
bench/world_to_screen_projection_tb.sv
